### rtl/core/mtrr_pkg.sv
// ----------------------------------------------------------------------------
// MTRR resolver package
// Shared request, response, token and configuration types plus code constants.
// ----------------------------------------------------------------------------
package mtrr_pkg;

    // Request opcodes
    localparam logic [1:0] OP_WRITE_FIXED = 2'd0;
    localparam logic [1:0] OP_WRITE_BASE  = 2'd1;
    localparam logic [1:0] OP_WRITE_MASK  = 2'd2;
    localparam logic [1:0] OP_LOOKUP      = 2'd3;

    // Result source codes
    localparam logic [2:0] SRC_ACK      = 3'd0;
    localparam logic [2:0] SRC_DISABLED = 3'd1;
    localparam logic [2:0] SRC_FIXED    = 3'd2;
    localparam logic [2:0] SRC_DEFAULT  = 3'd3;
    localparam logic [2:0] SRC_SINGLE   = 3'd4;
    localparam logic [2:0] SRC_COMBINED = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEFAULT_TYPE = 2'd0;
    localparam logic [1:0] CFG_MTRR_ENABLE  = 2'd1;
    localparam logic [1:0] CFG_FIXED_ENABLE = 2'd2;
    localparam logic [1:0] CFG_RANGE_COUNT  = 2'd3;

    // Memory types and fixed table geometry
    localparam logic [7:0] TYPE_UC      = 8'h00;
    localparam logic [7:0] TYPE_WT      = 8'h04;
    localparam logic [7:0] NOT_WT_WB    = 8'haf;
    localparam int         FIXED_WORDS  = 11;
    localparam int         MASK_VALID   = 11;
    localparam int         PAGE_SHIFT   = 12;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  table_index;
        logic [63:0] write_value;
        logic [51:0] phys_address;
    } req_t;

    typedef struct packed {
        logic [7:0] mem_type;
        logic [2:0] type_source;
    } rsp_t;

    // Request travelling down the range chain with its running match summary
    typedef struct packed {
        logic       valid;
        req_t       req;
        logic [7:0] seen;
        logic [7:0] last;
    } token_t;

    typedef struct packed {
        logic [7:0] default_type;
        logic       mtrr_enable;
        logic       fixed_enable;
        logic [3:0] range_count;
    } cfg_t;

endpackage

### rtl/core/mtrr_cell.sv
// ----------------------------------------------------------------------------
// MTRR range cell
// Holds one variable range (base and mask), takes writes addressed to it and
// folds its match into the token of each lookup passing through.
// ----------------------------------------------------------------------------
module mtrr_cell #(
    parameter int INDEX = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [3:0]      range_count,
    input  mtrr_pkg::token_t tok_in,
    output logic            ready_out,
    output mtrr_pkg::token_t tok_out,
    input  logic            ready_in
);
    import mtrr_pkg::*;

    logic [63:0] base_reg;
    logic [63:0] mask_reg;
    token_t      tok_reg;
    token_t      tok_next;
    logic        take;
    logic        active;
    logic        hit;
    logic [63:0] addr_ext;

    assign ready_out = !tok_reg.valid || ready_in;
    assign take      = tok_in.valid && ready_out;
    assign active    = 5'(INDEX) < {1'b0, range_count};
    assign addr_ext  = {12'd0, tok_in.req.phys_address};
    assign hit = active && mask_reg[MASK_VALID]
               && (((addr_ext ^ base_reg) & mask_reg) >> PAGE_SHIFT) == 64'd0;

    // Fold this range into the running summary
    always_comb begin
        tok_next = tok_in;
        if (tok_in.req.opcode == OP_LOOKUP && hit) begin
            tok_next.last = base_reg[7:0];
            if (base_reg[7:3] == 5'd0) begin
                tok_next.seen = tok_in.seen | (8'd1 << base_reg[2:0]);
            end
        end
    end

    // Advance the token and apply writes addressed to this range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
            base_reg      <= '0;
            mask_reg      <= '0;
        end else begin
            if (ready_out) begin
                tok_reg <= tok_next;
            end
            if (take && tok_in.req.table_index == 4'(INDEX)) begin
                if (tok_in.req.opcode == OP_WRITE_BASE) begin
                    base_reg <= tok_in.req.write_value;
                end
                if (tok_in.req.opcode == OP_WRITE_MASK) begin
                    mask_reg <= tok_in.req.write_value;
                end
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

### rtl/core/mtrr_resolve.sv
// ----------------------------------------------------------------------------
// MTRR result stage
// Holds the fixed-range table, picks the final type and registers the response.
// ----------------------------------------------------------------------------
module mtrr_resolve (
    input  logic             aclk,
    input  logic             aresetn,
    input  mtrr_pkg::cfg_t   cfg,
    input  mtrr_pkg::token_t tok_in,
    output logic             ready_out,
    output logic             m_valid,
    input  logic             m_ready,
    output mtrr_pkg::rsp_t   m_data
);
    import mtrr_pkg::*;

    logic [63:0] fixed_words_reg [FIXED_WORDS];
    logic        valid_reg;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;
    logic        take;
    logic [51:0] addr;
    logic [6:0]  byte_num;
    logic [63:0] fixed_word;
    logic [7:0]  fixed_type;
    logic [7:0]  seen;
    logic [7:0]  last;

    assign ready_out = !valid_reg || m_ready;
    assign take      = tok_in.valid && ready_out;
    assign addr      = tok_in.req.phys_address;
    assign seen      = tok_in.seen;
    assign last      = tok_in.last;

    // Locate the fixed table byte: 64K, 16K and 4K segments
    always_comb begin
        priority if (addr[19] == 1'b0) begin
            byte_num = {4'd0, addr[18:16]};
        end else if (addr[18] == 1'b0) begin
            byte_num = 7'd8 + {3'd0, addr[17:14]};
        end else begin
            byte_num = 7'd24 + {1'b0, addr[17:12]};
        end
    end

    assign fixed_word = (byte_num[6:3] < 4'(FIXED_WORDS)) ? fixed_words_reg[byte_num[6:3]]
                                                          : 64'd0;
    assign fixed_type = 8'(fixed_word >> {byte_num[2:0], 3'd0});

    // Pick the final type
    always_comb begin
        rsp_next.mem_type    = TYPE_UC;
        rsp_next.type_source = SRC_ACK;
        if (tok_in.req.opcode == OP_LOOKUP) begin
            priority if (!cfg.mtrr_enable) begin
                rsp_next.type_source = SRC_DISABLED;
            end else if (cfg.fixed_enable && addr[51:20] == 32'd0) begin
                rsp_next.mem_type    = fixed_type;
                rsp_next.type_source = SRC_FIXED;
            end else if (seen == 8'd0) begin
                rsp_next.mem_type    = cfg.default_type;
                rsp_next.type_source = SRC_DEFAULT;
            end else if (last[7:3] == 5'd0 && seen == (8'd1 << last[2:0])) begin
                rsp_next.mem_type    = last;
                rsp_next.type_source = SRC_SINGLE;
            end else begin
                rsp_next.type_source = SRC_COMBINED;
                priority if (seen[0]) begin
                    rsp_next.mem_type = TYPE_UC;
                end else if ((seen & NOT_WT_WB) == 8'd0) begin
                    rsp_next.mem_type = TYPE_WT;
                end else begin
                    rsp_next.mem_type = last;
                end
            end
        end
    end

    // Hold the response until taken; apply fixed table writes in order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            for (int i = 0; i < FIXED_WORDS; i++) begin
                fixed_words_reg[i] <= '0;
            end
        end else begin
            if (ready_out) begin
                valid_reg <= tok_in.valid;
                rsp_reg   <= rsp_next;
            end
            if (take && tok_in.req.opcode == OP_WRITE_FIXED
                && tok_in.req.table_index < 4'(FIXED_WORDS)) begin
                fixed_words_reg[tok_in.req.table_index] <= tok_in.req.write_value;
            end
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = rsp_reg;

endmodule

### rtl/core/mtrr_memory_type_resolver.sv
// ----------------------------------------------------------------------------
// MTRR memory type resolver
// Classifies physical addresses by memory type from fixed and variable MTRRs.
// ----------------------------------------------------------------------------
// Requests enter on s_valid/s_ready as s_data: a fixed word write, a range
// base or mask write, or a lookup. Every request returns one response on
// m_valid/m_ready as m_data; writes return an acknowledge with type 0.
// Requests pass a chain of VAR_RANGES range cells, each with its own register,
// then a result stage that holds the fixed table and the output register.
// One request per cycle is taken when the receiver keeps up. Writes travel
// the same chain, so they take effect in request order with respect to
// lookups.
// When the receiver stalls, each stage holds its request and the chain
// fills up behind the output register before s_ready drops. The user writes
// configuration via cfg_wr_en/cfg_index/cfg_wdata only while the block is
// idle; the block does not enforce it. Reset clears all ranges (invalid),
// the fixed table and the configuration registers, and empties the chain.
// ----------------------------------------------------------------------------
module mtrr_memory_type_resolver #(
    parameter int VAR_RANGES = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  mtrr_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output mtrr_pkg::rsp_t  m_data
);
    import mtrr_pkg::*;

    cfg_t   cfg_reg;
    token_t tok   [VAR_RANGES+1];
    logic   ready [VAR_RANGES+1];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEFAULT_TYPE: cfg_reg.default_type <= cfg_wdata;
                CFG_MTRR_ENABLE:  cfg_reg.mtrr_enable  <= cfg_wdata[0];
                CFG_FIXED_ENABLE: cfg_reg.fixed_enable <= cfg_wdata[0];
                CFG_RANGE_COUNT:  cfg_reg.range_count  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Start each request with an empty match summary
    always_comb begin
        tok[0].valid = s_valid;
        tok[0].req   = s_data;
        tok[0].seen  = 8'd0;
        tok[0].last  = 8'd0;
    end
    assign s_ready = ready[0];

    for (genvar g = 0; g < VAR_RANGES; g++) begin : g_cell
        mtrr_cell #(
            .INDEX(g)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .range_count(cfg_reg.range_count),
            .tok_in     (tok[g]),
            .ready_out  (ready[g]),
            .tok_out    (tok[g+1]),
            .ready_in   (ready[g+1])
        );
    end

    mtrr_resolve u_resolve (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .tok_in   (tok[VAR_RANGES]),
        .ready_out(ready[VAR_RANGES]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // A stall at the input can only come from a held response
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a held response");

    // With MTRRs disabled no lookup resolves through the tables
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !cfg_reg.mtrr_enable) |->
        (m_data.type_source == SRC_ACK || m_data.type_source == SRC_DISABLED))
        else $error("table result while MTRRs disabled");

    // Fixed table results only with fixed ranges enabled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.type_source == SRC_FIXED) |-> cfg_reg.fixed_enable)
        else $error("fixed result while fixed ranges disabled");

    // Write acknowledges carry type zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.type_source == SRC_ACK) |-> (m_data.mem_type == TYPE_UC))
        else $error("write acknowledge with nonzero type");

endmodule
